// ===== design/oale_pkg.sv =====
// Shared types, constants and the control store for the ordered array list engine.
// Used by oale_seq and ordered_array_list_engine_unit; no dependencies.
package oale_pkg;

	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW          = $clog2(DEPTH + 1);
	localparam int LW1         = LW + 1;
	localparam int POS_W       = 6;
	localparam int CMP_W       = (LW > POS_W) ? LW : POS_W;
	localparam int VAL_W       = 32;
	localparam int LEN_OUT_W   = 6;
	localparam int REM_OUT_W   = 6;
	localparam int IDX_OUT_W   = 5;
	localparam int UPC_W       = 5;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DEL_AT  = 2'd1,
		OP_DEL_VAL = 2'd2,
		OP_DUMP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADPOS = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_DISPATCH,
		C_FULL,
		C_POS_GT_LEN,
		C_LEN_ZERO,
		C_POS_GE_LEN,
		C_I_LE_POS,
		C_IP1_GE_LEN,
		C_I_GE_LEN,
		C_DUMP_LAST
	} cond_t;

	typedef enum logic [2:0] {
		I_HOLD, I_LEN, I_POS, I_ZERO, I_INC, I_DEC
	} iop_t;

	typedef enum logic [1:0] {
		RD_NONE, RD_I, RD_IM1, RD_IP1
	} rd_t;

	typedef enum logic [1:0] {
		WR_NONE, WR_I_RDATA, WR_POS_VALUE, WR_KEEP
	} wr_t;

	typedef enum logic [1:0] {
		LEN_HOLD, LEN_INC, LEN_DEC, LEN_KEEP
	} lenop_t;

	typedef enum logic [1:0] {
		EM_NONE, EM_STATUS, EM_REMOVED, EM_ELEM
	} emit_t;

	typedef logic [UPC_W-1:0] upc_t;

	// control store addresses
	localparam upc_t U_IDLE     = 5'd0;
	localparam upc_t U_I_FULLCK = 5'd1;
	localparam upc_t U_I_POSCK  = 5'd2;
	localparam upc_t U_I_RD     = 5'd3;
	localparam upc_t U_I_WR     = 5'd4;
	localparam upc_t U_I_PUT    = 5'd5;
	localparam upc_t U_I_OK     = 5'd6;
	localparam upc_t U_I_FULL   = 5'd7;
	localparam upc_t U_I_BAD    = 5'd8;
	localparam upc_t U_D_EMPCK  = 5'd9;
	localparam upc_t U_D_POSCK  = 5'd10;
	localparam upc_t U_D_RD     = 5'd11;
	localparam upc_t U_D_WR     = 5'd12;
	localparam upc_t U_D_DONE   = 5'd13;
	localparam upc_t U_D_OK     = 5'd14;
	localparam upc_t U_D_EMPTY  = 5'd15;
	localparam upc_t U_D_BAD    = 5'd16;
	localparam upc_t U_V_INIT   = 5'd17;
	localparam upc_t U_V_RD     = 5'd18;
	localparam upc_t U_V_KEEP   = 5'd19;
	localparam upc_t U_V_DONE   = 5'd20;
	localparam upc_t U_V_OK     = 5'd21;
	localparam upc_t U_P_INIT   = 5'd22;
	localparam upc_t U_P_RD     = 5'd23;
	localparam upc_t U_P_EMIT   = 5'd24;
	localparam upc_t U_P_NEXT   = 5'd25;
	localparam upc_t U_P_EMPTY  = 5'd26;

	typedef struct packed {
		cond_t   cond;
		upc_t    target;
		iop_t    i_op;
		rd_t     rd;
		wr_t     wr;
		lenop_t  len_op;
		logic    k_clr;
		emit_t   emit;
		status_t st;
	} ctrl_t;

	// condition flags from the datapath to the sequencer
	typedef struct packed {
		logic full;
		logic pos_gt_len;
		logic len_zero;
		logic pos_ge_len;
		logic i_le_pos;
		logic ip1_ge_len;
		logic i_ge_len;
		logic dump_last;
	} flags_t;

	function automatic upc_t entry_of(input op_t op);
		upc_t e;
		case (op)
			OP_INSERT:  e = U_I_FULLCK;
			OP_DEL_AT:  e = U_D_EMPCK;
			OP_DEL_VAL: e = U_V_INIT;
			OP_DUMP:    e = U_P_INIT;
			default:    e = U_IDLE;
		endcase
		return e;
	endfunction

	function automatic ctrl_t ucode(input upc_t s);
		ctrl_t w;
		case (s)
			U_IDLE:     w = '{C_DISPATCH, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			// insert: shift [pos, len) up by one, top down
			U_I_FULLCK: w = '{C_FULL, U_I_FULL, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_I_POSCK:  w = '{C_POS_GT_LEN, U_I_BAD, I_LEN, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_I_RD:     w = '{C_I_LE_POS, U_I_PUT, I_HOLD, RD_IM1, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_I_WR:     w = '{C_ALWAYS, U_I_RD, I_DEC, RD_NONE, WR_I_RDATA, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_I_PUT:    w = '{C_NEXT, U_IDLE, I_HOLD, RD_NONE, WR_POS_VALUE, LEN_INC,
				1'b0, EM_NONE, STAT_OK};
			U_I_OK:     w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_STATUS, STAT_OK};
			U_I_FULL:   w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_STATUS, STAT_FULL};
			U_I_BAD:    w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_STATUS, STAT_BADPOS};
			// delete at: shift (pos, len) down by one
			U_D_EMPCK:  w = '{C_LEN_ZERO, U_D_EMPTY, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_D_POSCK:  w = '{C_POS_GE_LEN, U_D_BAD, I_POS, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_D_RD:     w = '{C_IP1_GE_LEN, U_D_DONE, I_HOLD, RD_IP1, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_D_WR:     w = '{C_ALWAYS, U_D_RD, I_INC, RD_NONE, WR_I_RDATA, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_D_DONE:   w = '{C_NEXT, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_DEC,
				1'b0, EM_NONE, STAT_OK};
			U_D_OK:     w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_STATUS, STAT_OK};
			U_D_EMPTY:  w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_STATUS, STAT_EMPTY};
			U_D_BAD:    w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_STATUS, STAT_BADPOS};
			// delete value: compact non-matching entries to the keep pointer
			U_V_INIT:   w = '{C_NEXT, U_IDLE, I_ZERO, RD_NONE, WR_NONE, LEN_HOLD,
				1'b1, EM_NONE, STAT_OK};
			U_V_RD:     w = '{C_I_GE_LEN, U_V_DONE, I_HOLD, RD_I, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_V_KEEP:   w = '{C_ALWAYS, U_V_RD, I_INC, RD_NONE, WR_KEEP, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_V_DONE:   w = '{C_NEXT, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_KEEP,
				1'b0, EM_NONE, STAT_OK};
			U_V_OK:     w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_REMOVED, STAT_OK};
			// dump: read, emit, then read the next entry and loop back to emit
			U_P_INIT:   w = '{C_LEN_ZERO, U_P_EMPTY, I_ZERO, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_P_RD:     w = '{C_NEXT, U_IDLE, I_HOLD, RD_I, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_P_EMIT:   w = '{C_DUMP_LAST, U_IDLE, I_INC, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_ELEM, STAT_OK};
			U_P_NEXT:   w = '{C_ALWAYS, U_P_EMIT, I_HOLD, RD_I, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
			U_P_EMPTY:  w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_STATUS, STAT_OK};
			default:    w = '{C_ALWAYS, U_IDLE, I_HOLD, RD_NONE, WR_NONE, LEN_HOLD,
				1'b0, EM_NONE, STAT_OK};
		endcase
		return w;
	endfunction

endpackage

// ===== design/ordered_array_list_engine_unit.sv =====
// Ordered array list engine: list memory, pointers, length and result register.
// Depends on oale_pkg and oale_seq.
//
// Holds an ordered list of up to DEPTH signed words in a single-port-write,
// registered-read memory. An item is taken only while the sequencer is idle;
// the result register lets the next item in while a result still waits.
// Each list entry moved or scanned takes a read step and then a write step
// on the memory port; a dump takes a read step and an emit step per entry.
// A stalled output holds the sequencer on its emit step.
module ordered_array_list_engine_unit
	import oale_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [5:0] position, [37:6] value, [39:38] zero
	input  logic [1:0]  s_tuser,  // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [1:0] status, [7:2] length_after, [13:8] removed_count,
	                              // [18:14] element_index, [50:19] element_value, [55:51] zero
	output logic        m_tlast
);

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [LW-1:0]           len_q;
	logic [LW-1:0]           i_q;
	logic [LW-1:0]           k_q;
	logic [LW-1:0]           rem_q;

	logic [1:0]              o_status_q;
	logic [LEN_OUT_W-1:0]    o_len_q;
	logic [REM_OUT_W-1:0]    o_rem_q;
	logic [IDX_OUT_W-1:0]    o_idx_q;
	logic signed [VAL_W-1:0] o_val_q;
	logic                    o_last_q;
	logic                    m_valid_q;

	ctrl_t   ctrl;
	flags_t  flags;
	logic    idle;
	logic    start;
	logic    stall;
	logic    emit;
	logic    ren;
	logic    wen;
	logic    keep_hit;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic signed [VAL_W-1:0] wdata;
	logic [LW-1:0] dump_n;

	assign s_tready = idle;
	assign start    = s_tvalid && idle;
	assign emit     = (ctrl.emit != EM_NONE);
	assign stall    = emit && m_valid_q && !m_tready;
	assign keep_hit = (rdata_q != val_q);

	// dump emits at most MAX_RESULTS entries
	assign dump_n = (LW1'(len_q) > LW1'(MAX_RESULTS)) ? LW'(MAX_RESULTS) : len_q;

	always_comb begin
		flags.full       = (len_q == LW'(DEPTH));
		flags.pos_gt_len = (CMP_W'(pos_q) > CMP_W'(len_q));
		flags.len_zero   = (len_q == '0);
		flags.pos_ge_len = (CMP_W'(pos_q) >= CMP_W'(len_q));
		flags.i_le_pos   = (CMP_W'(i_q) <= CMP_W'(pos_q));
		flags.ip1_ge_len = ((LW1'(i_q) + LW1'(1)) >= LW1'(len_q));
		flags.i_ge_len   = (i_q >= len_q);
		flags.dump_last  = ((LW1'(i_q) + LW1'(1)) == LW1'(dump_n));
	end

	oale_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op_t'(s_tuser)),
		.stall  (stall),
		.flags  (flags),
		.ctrl   (ctrl),
		.idle   (idle)
	);

	// memory port selection
	always_comb begin
		ren   = 1'b0;
		raddr = i_q[AW-1:0];
		case (ctrl.rd)
			RD_I: begin
				ren   = 1'b1;
				raddr = i_q[AW-1:0];
			end
			RD_IM1: begin
				ren   = 1'b1;
				raddr = AW'(i_q - LW'(1));
			end
			RD_IP1: begin
				ren   = 1'b1;
				raddr = AW'(i_q + LW'(1));
			end
			default: begin
				ren   = 1'b0;
			end
		endcase
		wen   = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = rdata_q;
		case (ctrl.wr)
			WR_I_RDATA: begin
				wen = 1'b1;
			end
			WR_POS_VALUE: begin
				wen   = 1'b1;
				waddr = AW'(pos_q);
				wdata = val_q;
			end
			WR_KEEP: begin
				wen   = keep_hit;
				waddr = k_q[AW-1:0];
			end
			default: begin
				wen = 1'b0;
			end
		endcase
		if (stall) begin
			ren = 1'b0;
			wen = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pos_q <= s_tdata[POS_W-1:0];
			val_q <= s_tdata[POS_W+VAL_W-1:POS_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			i_q   <= '0;
			k_q   <= '0;
			rem_q <= '0;
		end else if (!stall) begin
			case (ctrl.i_op)
				I_LEN:   i_q <= len_q;
				I_POS:   i_q <= LW'(pos_q);
				I_ZERO:  i_q <= '0;
				I_INC:   i_q <= i_q + LW'(1);
				I_DEC:   i_q <= i_q - LW'(1);
				default: i_q <= i_q;
			endcase
			if (ctrl.k_clr) begin
				k_q <= '0;
			end else if (ctrl.wr == WR_KEEP && keep_hit) begin
				k_q <= k_q + LW'(1);
			end
			case (ctrl.len_op)
				LEN_INC: len_q <= len_q + LW'(1);
				LEN_DEC: len_q <= len_q - LW'(1);
				LEN_KEEP: begin
					len_q <= k_q;
					rem_q <= len_q - k_q;
				end
				default: len_q <= len_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit && !stall) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !stall) begin
			o_status_q <= ctrl.st;
			o_len_q    <= LEN_OUT_W'(len_q);
			o_rem_q    <= '0;
			o_idx_q    <= '0;
			o_val_q    <= '0;
			o_last_q   <= 1'b1;
			case (ctrl.emit)
				EM_REMOVED: begin
					o_rem_q <= REM_OUT_W'(rem_q);
				end
				EM_ELEM: begin
					o_idx_q  <= IDX_OUT_W'(i_q);
					o_val_q  <= rdata_q;
					o_last_q <= flags.dump_last;
				end
				default: begin
					o_rem_q <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'b0, o_val_q, o_idx_q, o_rem_q, o_len_q, o_status_q};

endmodule

// ===== design/oale_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on oale_pkg.
module oale_seq
	import oale_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  op_t    op,
	input  logic   stall,
	input  flags_t flags,
	output ctrl_t  ctrl,
	output logic   idle
);

	upc_t upc_q;
	upc_t upc_d;
	logic jump;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		ctrl = ucode(upc_q);
		idle = (upc_q == U_IDLE);
		case (ctrl.cond)
			C_ALWAYS:     jump = 1'b1;
			C_FULL:       jump = flags.full;
			C_POS_GT_LEN: jump = flags.pos_gt_len;
			C_LEN_ZERO:   jump = flags.len_zero;
			C_POS_GE_LEN: jump = flags.pos_ge_len;
			C_I_LE_POS:   jump = flags.i_le_pos;
			C_IP1_GE_LEN: jump = flags.ip1_ge_len;
			C_I_GE_LEN:   jump = flags.i_ge_len;
			C_DUMP_LAST:  jump = flags.dump_last;
			default:      jump = 1'b0;
		endcase
		if (stall) begin
			upc_d = upc_q;
		end else if (ctrl.cond == C_DISPATCH) begin
			upc_d = start ? entry_of(op) : U_IDLE;
		end else if (jump) begin
			upc_d = ctrl.target;
		end else begin
			upc_d = upc_q + upc_t'(1);
		end
	end

endmodule

// ===== sim/ordered_array_list_engine_unit_test.sv =====
// Self-checking testbench for ordered_array_list_engine_unit: insert, delete, delete-value, dump.
// Depends on oale_pkg and the design sources; drives random gaps on both stream sides.
`timescale 1ns / 100ps

module ordered_array_list_engine_unit_test
	import oale_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		status_t     status;
		logic [5:0]  length_after;
		logic [5:0]  removed_count;
		logic [4:0]  element_index;
		logic [31:0] element_value;
		logic        last;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [5:0] position, [37:6] value, [39:38] zero
	logic [1:0]  s_tuser = '0;   // [1:0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // [1:0] status, [7:2] length_after, [13:8] removed_count,
	                             // [18:14] element_index, [50:19] element_value
	logic        m_tlast;

	logic [31:0]  shadow_list[$];
	list_result_t pending_results[$];
	logic [31:0]  value_pool[4];
	int           mismatch_count = 0;
	int           idle_cycles = 0;
	int           sink_stall = 0;
	bit           no_gaps = 1'b0;

	ordered_array_list_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void push_result(status_t st, int len, int removed, int idx,
			logic [31:0] elem, logic last);
		list_result_t res;
		res.status        = st;
		res.length_after  = len[5:0];
		res.removed_count = removed[5:0];
		res.element_index = idx[4:0];
		res.element_value = elem;
		res.last          = last;
		pending_results.push_back(res);
	endfunction

	// applies one operation to the shadow list and queues the results it yields
	function automatic void predict_list_op(op_t op, logic [5:0] pos, logic [31:0] val);
		int len;
		logic [31:0] kept[$];
		len = shadow_list.size();
		case (op)
			OP_INSERT: begin
				if (len >= DEPTH)
					push_result(STAT_FULL, len, 0, 0, '0, 1'b1);
				else if (int'(pos) > len)
					push_result(STAT_BADPOS, len, 0, 0, '0, 1'b1);
				else begin
					shadow_list.insert(int'(pos), val);
					push_result(STAT_OK, len + 1, 0, 0, '0, 1'b1);
				end
			end
			OP_DEL_AT: begin
				if (len == 0)
					push_result(STAT_EMPTY, 0, 0, 0, '0, 1'b1);
				else if (int'(pos) >= len)
					push_result(STAT_BADPOS, len, 0, 0, '0, 1'b1);
				else begin
					shadow_list.delete(int'(pos));
					push_result(STAT_OK, len - 1, 0, 0, '0, 1'b1);
				end
			end
			OP_DEL_VAL: begin
				foreach (shadow_list[i])
					if (shadow_list[i] != val)
						kept.push_back(shadow_list[i]);
				shadow_list = kept;
				push_result(STAT_OK, kept.size(), len - kept.size(), 0, '0, 1'b1);
			end
			default: begin
				if (len == 0)
					push_result(STAT_OK, 0, 0, 0, '0, 1'b1);
				else
					for (int i = 0; i < len && i < MAX_RESULTS; i++)
						push_result(STAT_OK, len, 0, i, shadow_list[i],
							(i + 1 == len) || (i + 1 == MAX_RESULTS));
			end
		endcase
	endfunction

	// valid is left high after acceptance; drain_list, or the next call when it draws a gap, lowers it
	task automatic send_item(op_t op, logic [5:0] pos, logic [31:0] val);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, val, pos};
		do
			@(posedge clk);
		while (!s_tready);
		predict_list_op(op, pos, val);
	endtask

	task automatic drain_list();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return value_pool[$urandom_range(0, 3)];
		if (r < 55 && shadow_list.size() != 0)
			return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
		return $urandom;
	endfunction

	task automatic test_empty_list();
		send_item(OP_DUMP, 6'd0, 32'h0);
		send_item(OP_DEL_AT, 6'd0, 32'h0);
		send_item(OP_DEL_AT, 6'd63, 32'hFFFF_FFFF);
		send_item(OP_DEL_VAL, 6'd0, 32'h8000_0000);
		send_item(OP_INSERT, 6'd1, 32'h1234_5678);
		send_item(OP_INSERT, 6'd63, 32'h7FFF_FFFF);
		drain_list();
	endtask

	task automatic test_insert_delete();
		send_item(OP_INSERT, 6'd0, 32'h8000_0000);
		send_item(OP_INSERT, 6'd1, 32'h7FFF_FFFF);
		send_item(OP_INSERT, 6'd0, 32'h0000_0000);
		send_item(OP_INSERT, 6'd3, 32'hFFFF_FFFF);   // append at the tail
		send_item(OP_INSERT, 6'd5, 32'h0000_0001);   // one past the tail
		send_item(OP_INSERT, 6'd2, 32'h7FFF_FFFF);
		send_item(OP_DUMP, 6'd0, 32'h0);
		send_item(OP_DEL_AT, 6'd5, 32'h0);           // position equals length
		send_item(OP_DEL_AT, 6'd63, 32'h0);
		send_item(OP_DEL_AT, 6'd0, 32'h0);
		send_item(OP_DEL_VAL, 6'd0, 32'h7FFF_FFFF);  // two matches
		send_item(OP_DEL_VAL, 6'd17, 32'h0000_3039); // no match
		send_item(OP_DUMP, 6'd0, 32'h0);
		send_item(OP_DEL_AT, 6'd1, 32'h0);
		send_item(OP_DEL_VAL, 6'd0, 32'h8000_0000);  // empties the list
		drain_list();
	endtask

	task automatic test_full_list();
		int len;
		while (shadow_list.size() < DEPTH) begin
			len = shadow_list.size();
			send_item(OP_INSERT, 6'($urandom_range(0, len)), pick_value());
		end
		send_item(OP_INSERT, 6'd0, 32'h5555_5555);
		send_item(OP_INSERT, 6'(DEPTH), 32'hAAAA_AAAA);
		send_item(OP_INSERT, 6'd63, 32'h0);
		send_item(OP_DUMP, 6'd0, 32'h0);
		send_item(OP_DEL_AT, 6'(DEPTH - 1), 32'h0);
		send_item(OP_DEL_VAL, 6'd0, value_pool[$urandom_range(0, 3)]);
		while (shadow_list.size() != 0) begin
			len = shadow_list.size();
			send_item(OP_DEL_AT, 6'($urandom_range(0, len - 1)), $urandom);
		end
		drain_list();
	endtask

	task automatic test_random_ops(int count);
		int r, len;
		bit grow;
		op_t op;
		logic [5:0] pos;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				grow = $urandom_range(0, 1);
			no_gaps = (n % 70) >= 55;
			r = $urandom_range(0, 99);
			if (grow)
				op = (r < 55) ? OP_INSERT : (r < 70) ? OP_DEL_AT : (r < 88) ? OP_DEL_VAL : OP_DUMP;
			else
				op = (r < 30) ? OP_INSERT : (r < 65) ? OP_DEL_AT : (r < 90) ? OP_DEL_VAL : OP_DUMP;
			len = shadow_list.size();
			// a few positions are noise across the whole field
			if ($urandom_range(0, 99) < 15)
				pos = 6'($urandom_range(0, 63));
			else if (op == OP_INSERT)
				pos = 6'($urandom_range(0, len));
			else if (len > 0)
				pos = 6'($urandom_range(0, len - 1));
			else
				pos = 6'($urandom_range(0, 63));
			send_item(op, pos, pick_value());
		end
		no_gaps = 1'b0;
		drain_list();
	endtask

	// result sink with random back-pressure
	always @(posedge clk) begin
		if (sink_stall > 0) begin
			sink_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!no_gaps)
				sink_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		list_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status        = status_t'(m_tdata[1:0]);
			got.length_after  = m_tdata[7:2];
			got.removed_count = m_tdata[13:8];
			got.element_index = m_tdata[18:14];
			got.element_value = m_tdata[50:19];
			got.last          = m_tlast;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: result with none expected: ", $realtime,
						"st=%0d len=%0d rm=%0d idx=%0d val=%h last=%b",
						got.status, got.length_after, got.removed_count,
						got.element_index, got.element_value, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: mismatch ", $realtime,
							"exp st=%0d len=%0d rm=%0d idx=%0d val=%h last=%b",
							want.status, want.length_after, want.removed_count,
							want.element_index, want.element_value, want.last,
							" / got st=%0d len=%0d rm=%0d idx=%0d val=%h last=%b",
							got.status, got.length_after, got.removed_count,
							got.element_index, got.element_value, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = $urandom;
		value_pool[3] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_empty_list();
		test_insert_delete();
		test_full_list();
		test_random_ops(130);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
design/oale_pkg.sv
design/oale_seq.sv
design/ordered_array_list_engine_unit.sv
sim/ordered_array_list_engine_unit_test.sv
